[src/cmdr_pkg.sv]
// Shared types and constants for the command/response frame master.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package cmdr_pkg;

  // Frame geometry: sync, address, command, sequence, checksum
  localparam int FRAME_BYTES  = 5;
  localparam int HDR_BYTES    = FRAME_BYTES - 1;
  localparam int BYTE_IDX_W   = $clog2(FRAME_BYTES);

  // Timeout counter width default and register width
  localparam int TIMEOUT_BITS_DEF = 16;
  localparam int TIMEOUT_REG_W    = 16;

  // Job queue between front and back
  localparam int JOBQ_DEPTH = 4;
  localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
  localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NACK        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_LINK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 3'd4;

  localparam logic [7:0]               SYNC_RESET    = 8'd0;
  localparam logic [7:0]               ACK_RESET     = 8'd0;
  localparam logic [7:0]               LINK_RESET    = 8'd0;
  localparam logic [TIMEOUT_REG_W-1:0] TIMEOUT_RESET = 16'd1000;

  typedef enum logic [1:0] {
    FUNC_START = 2'd0,
    FUNC_RESP  = 2'd1,
    FUNC_TICK  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NACK      = 3'd1,
    ST_TIMEOUT   = 3'd2,
    ST_SYNC_ERR  = 3'd3,
    ST_CSUM_ERR  = 3'd4,
    ST_SEQ_ERR   = 3'd5
  } status_t;

  localparam logic KIND_TX     = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Live configuration seen by the front end
  typedef struct packed {
    logic [7:0]               sync_value;
    logic [7:0]               ack_value;
    logic [7:0]               second_link_address;
    logic [TIMEOUT_REG_W-1:0] response_timeout_ticks;
  } cmdr_cfg_t;

  // One job: either a whole command frame or one status report
  typedef struct packed {
    logic       is_status;
    logic [7:0] sync_byte;
    logic [7:0] addr;
    logic [7:0] cmd;
    logic [7:0] seq;
    logic       link;
    status_t    status;
  } cmdr_job_t;

endpackage

[src/cmdr_front.sv]
// Front end: accepts input words, tracks the transaction and queues jobs.
// Depends on cmdr_pkg.
`timescale 1ns / 1ps

module cmdr_front import cmdr_pkg::*; #(
  parameter int TIMEOUT_BITS = TIMEOUT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  cmdr_cfg_t  cfg,
  input  logic       in_valid,
  input  logic [1:0] func,
  input  logic [7:0] target_address,
  input  logic [7:0] command_code,
  input  logic [7:0] rx_byte,
  output logic       job_push,
  output cmdr_job_t  job
);

  localparam int CMP_W = (TIMEOUT_BITS > TIMEOUT_REG_W) ? TIMEOUT_BITS : TIMEOUT_REG_W;
  localparam int HDR_IDX_W = $clog2(HDR_BYTES);

  logic [7:0]              sequence_counter;
  logic [7:0]              pending_sequence;
  logic                    waiting;
  logic [2:0]              rx_count;
  logic [7:0]              rx_store [HDR_BYTES];
  logic [7:0]              running_xor;
  logic [TIMEOUT_BITS-1:0] timeout_count;

  logic [TIMEOUT_BITS-1:0] timeout_inc;
  logic                    timed_out;
  logic                    hdr_phase;
  logic                    is_start;
  logic                    is_resp;
  logic                    is_tick;
  logic                    resp_done;
  logic                    tick_done;
  status_t                 resp_status;

  // Decode the word
  assign is_start  = in_valid && (func == FUNC_START);
  assign is_resp   = in_valid && (func == FUNC_RESP) && waiting;
  assign is_tick   = in_valid && (func == FUNC_TICK) && waiting;
  assign hdr_phase = rx_count < 3'(HDR_BYTES);
  assign resp_done = is_resp && !hdr_phase;

  // Saturating tick count and timeout compare
  assign timeout_inc = (&timeout_count) ? timeout_count : timeout_count + 1'b1;
  assign timed_out   = CMP_W'(timeout_inc) >= CMP_W'(cfg.response_timeout_ticks);
  assign tick_done   = is_tick && timed_out;

  // Check the response in priority order
  always_comb begin
    if (rx_store[0] != cfg.sync_value) begin
      resp_status = ST_SYNC_ERR;
    end else if (rx_byte != running_xor) begin
      resp_status = ST_CSUM_ERR;
    end else if (rx_store[3] != pending_sequence) begin
      resp_status = ST_SEQ_ERR;
    end else if (rx_store[2] == cfg.ack_value) begin
      resp_status = ST_OK;
    end else begin
      resp_status = ST_NACK;
    end
  end

  // Build the job for the queue
  always_comb begin
    job_push      = is_start || resp_done || tick_done;
    job.is_status = !is_start;
    job.sync_byte = cfg.sync_value;
    job.addr      = target_address;
    job.cmd       = command_code;
    job.seq       = is_start ? sequence_counter : pending_sequence;
    job.link      = (target_address == cfg.second_link_address);
    job.status    = resp_done ? resp_status : ST_TIMEOUT;
  end

  // Transaction state
  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_counter <= '0;
      pending_sequence <= '0;
      waiting          <= 1'b0;
      rx_count         <= '0;
      running_xor      <= '0;
      timeout_count    <= '0;
    end else if (is_start) begin
      pending_sequence <= sequence_counter;
      sequence_counter <= sequence_counter + 8'd1;
      waiting          <= 1'b1;
      rx_count         <= '0;
      running_xor      <= '0;
      timeout_count    <= '0;
    end else if (resp_done || tick_done) begin
      waiting       <= 1'b0;
      rx_count      <= '0;
      running_xor   <= '0;
      timeout_count <= '0;
    end else if (is_resp) begin
      running_xor <= running_xor ^ rx_byte;
      rx_count    <= rx_count + 3'd1;
    end else if (is_tick) begin
      timeout_count <= timeout_inc;
    end
  end

  // Capture header bytes of the response
  always_ff @(posedge clk) begin
    if (is_resp && hdr_phase) begin
      rx_store[rx_count[HDR_IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule

[src/cmdr_jobq.sv]
// Small register queue of jobs between the front and back ends.
// Depends on cmdr_pkg.
`timescale 1ns / 1ps

module cmdr_jobq import cmdr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmdr_job_t din,
  output logic      full,
  input  logic      pop,
  output cmdr_job_t dout,
  output logic      empty
);

  cmdr_job_t             slots [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr;
  logic [JOBQ_PTR_W-1:0] rd_ptr;
  logic [JOBQ_CNT_W-1:0] count;
  logic                  do_push;
  logic                  do_pop;

  assign full    = (count == JOBQ_CNT_W'(JOBQ_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  // Store incoming job
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[src/cmdr_back.sv]
// Back end: expands jobs into frame bytes or status words and holds the
// output register. Depends on cmdr_pkg.
`timescale 1ns / 1ps

module cmdr_back import cmdr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       job_valid,
  input  cmdr_job_t  job,
  output logic       job_pop,
  output logic       empty,
  input  logic       pop,
  output logic       kind,
  output logic [7:0] tx_byte,
  output logic       link_select,
  output logic       last_byte,
  output logic [2:0] status_code,
  output logic [7:0] sequence_sent
);

  logic [BYTE_IDX_W-1:0] byte_idx;
  logic                  out_valid;
  logic                  load;
  logic                  final_byte;
  logic                  job_last;
  logic [7:0]            frame_byte;

  assign load       = job_valid && (!out_valid || pop);
  assign final_byte = (byte_idx == BYTE_IDX_W'(FRAME_BYTES - 1));
  assign job_last   = job.is_status || final_byte;
  assign job_pop    = load && job_last;
  assign empty      = !out_valid;

  // Pick the frame byte for the current position
  always_comb begin
    case (byte_idx)
      BYTE_IDX_W'(0): frame_byte = job.sync_byte;
      BYTE_IDX_W'(1): frame_byte = job.addr;
      BYTE_IDX_W'(2): frame_byte = job.cmd;
      BYTE_IDX_W'(3): frame_byte = job.seq;
      default:        frame_byte = job.sync_byte ^ job.addr ^ job.cmd ^ job.seq;
    endcase
  end

  // Step through the frame
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        byte_idx  <= job_last ? '0 : byte_idx + 1'b1;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (load) begin
      sequence_sent <= job.seq;
      if (job.is_status) begin
        kind        <= KIND_STATUS;
        tx_byte     <= '0;
        link_select <= 1'b0;
        last_byte   <= 1'b0;
        status_code <= job.status;
      end else begin
        kind        <= KIND_TX;
        tx_byte     <= frame_byte;
        link_select <= job.link;
        last_byte   <= final_byte;
        status_code <= ST_OK;
      end
    end
  end

endmodule

[src/command_response_frame_master.sv]
// Top level of the command/response frame master: configuration registers
// and the front end, job queue and back end. Depends on cmdr_pkg.
//
// Usage:
//   Input channel (push/full): one word per cycle unless full. func selects
//   start (target_address, command_code), response byte (rx_byte) or tick.
//   Result channel (empty/pop): each word is either one transmit byte of a
//   five-byte frame (sync, address, command, sequence, XOR checksum) or one
//   transaction status (ok, nack, timeout, sync, checksum or sequence error).
//   Configuration: cfg_write/cfg_index/cfg_data, one register per write.
// Path: a word's job goes into the job queue, then into the output register.
// Throughput: one input word per cycle while the four-entry job queue has
//   room; the back end issues one result word per cycle while pop is high,
//   and a start expands into five result words.
// Stall: when pop stays low the output register holds, the job queue fills
//   and full rises; words that produce no result still wait on full.
// Reset: sequence counter, transaction state and queues clear; the
//   registers return to sync 0, ack 0, second link address 0, timeout 1000.
`timescale 1ns / 1ps

module command_response_frame_master import cmdr_pkg::*; #(
  parameter int TIMEOUT_BITS = TIMEOUT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  push,
  output logic                  full,
  input  logic [1:0]            func,
  input  logic [7:0]            target_address,
  input  logic [7:0]            command_code,
  input  logic [7:0]            rx_byte,
  output logic                  empty,
  input  logic                  pop,
  output logic                  kind,
  output logic [7:0]            tx_byte,
  output logic                  link_select,
  output logic                  last_byte,
  output logic [2:0]            status_code,
  output logic [7:0]            sequence_sent
);

  cmdr_cfg_t cfg;
  logic      in_valid;
  logic      job_push;
  cmdr_job_t job_in;
  logic      job_pop;
  cmdr_job_t job_out;
  logic      jobq_empty;

  // Register writes; the nack value is accepted but any non-ack status
  // reports as nack, so it is not stored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sync_value             <= SYNC_RESET;
      cfg.ack_value              <= ACK_RESET;
      cfg.second_link_address    <= LINK_RESET;
      cfg.response_timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SYNC:        cfg.sync_value             <= cfg_data[7:0];
        CFG_ACK:         cfg.ack_value              <= cfg_data[7:0];
        CFG_NACK:        ;
        CFG_SECOND_LINK: cfg.second_link_address    <= cfg_data[7:0];
        CFG_TIMEOUT:     cfg.response_timeout_ticks <= cfg_data[TIMEOUT_REG_W-1:0];
        default:         ;
      endcase
    end
  end

  assign in_valid = push && !full;

  cmdr_front #(
    .TIMEOUT_BITS (TIMEOUT_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .func           (func),
    .target_address (target_address),
    .command_code   (command_code),
    .rx_byte        (rx_byte),
    .job_push       (job_push),
    .job            (job_in)
  );

  cmdr_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .din   (job_in),
    .full  (full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (jobq_empty)
  );

  cmdr_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (!jobq_empty),
    .job           (job_out),
    .job_pop       (job_pop),
    .empty         (empty),
    .pop           (pop),
    .kind          (kind),
    .tx_byte       (tx_byte),
    .link_select   (link_select),
    .last_byte     (last_byte),
    .status_code   (status_code),
    .sequence_sent (sequence_sent)
  );

endmodule
